// ===== rtl/core/acv_pkg.sv =====
// ----------------------------------------------------------------------------
// acv_pkg
// Shared types and constants of the ANSI text console.
// ----------------------------------------------------------------------------
package acv_pkg;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  char_code;
    logic [10:0] cell_address;
    logic [7:0]  attr_value;
  } item_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_offset;
    logic [7:0]  current_attr;
    logic [15:0] cell_data;
    logic [2:0]  escape_stage;
  } result_t;

  localparam logic [1:0] CMD_PUT  = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_ATTR = 2'd2;
  // unassigned code: no state change
  localparam logic [1:0] CMD_RSVD = 2'd3;

  localparam logic [7:0] CH_ESC   = 8'd27;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LBR   = 8'h5b;
  localparam logic [7:0] CH_J     = 8'h4a;
  localparam logic [7:0] CH_M     = 8'h6d;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_4     = 8'h34;
  localparam logic [7:0] CH_7     = 8'h37;

  localparam logic [7:0] ATTR_NORMAL  = 8'h07;
  localparam logic [7:0] ATTR_BRIGHT  = 8'h0f;
  localparam logic [7:0] ATTR_REVERSE = 8'h70;

  localparam logic [2:0] ESC_IDLE  = 3'd0;
  localparam logic [2:0] ESC_SEEN  = 3'd1;
  localparam logic [2:0] ESC_CSI   = 3'd2;
  localparam logic [2:0] ESC_DIGIT = 3'd3;
  localparam logic [2:0] ESC_COLOR = 3'd4;

  function automatic logic [3:0] colour_map(input logic [2:0] idx);
    case (idx)
      3'd0: colour_map = 4'd0;
      3'd1: colour_map = 4'd4;
      3'd2: colour_map = 4'd2;
      3'd3: colour_map = 4'd14;
      3'd4: colour_map = 4'd1;
      3'd5: colour_map = 4'd5;
      3'd6: colour_map = 4'd3;
      default: colour_map = 4'd15;
    endcase
  endfunction

endpackage

// ===== rtl/core/ansi_text_console_unit.sv =====
// ----------------------------------------------------------------------------
// ansi_text_console_unit
// Text terminal with cell store, cursor and a small ANSI escape parser.
// ----------------------------------------------------------------------------
// An item is taken from the queue head in the idle state; its result is
// registered in the emit state (a cell read passes a read state first).
// A scroll or a clear adds a sweep set by the single write port of the cell
// RAM walking every cell. No item is taken before the last result is emitted.
// Reset: synchronous; afterwards a clearing pass over all ROWS*COLUMNS cells
// (2000 by default) blanks the store while full stays high.
module ansi_text_console_unit
  import acv_pkg::*;
#(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  output logic    full,
  input  item_t   item,
  output logic    empty,
  input  logic    pop,
  output result_t result
);
  logic  avail;
  logic  take;
  logic  hold;
  logic  res_valid;
  item_t head;

  acv_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .hold(hold), .avail(avail), .head(head), .take(take)
  );

  acv_back #(.COLUMNS(COLUMNS), .ROWS(ROWS), .TAB_WIDTH(TAB_WIDTH)) u_back (
    .clk(clk), .rst(rst), .avail(avail), .head(head), .take(take),
    .init_busy(hold), .res_valid(res_valid), .res(result), .pop(pop)
  );

  assign empty = !res_valid;
endmodule

// ===== rtl/core/acv_ram.sv =====
// ----------------------------------------------------------------------------
// acv_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module acv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/acv_front.sv =====
// ----------------------------------------------------------------------------
// acv_front
// Input queue: takes beats and holds them until the executor pulls them.
// ----------------------------------------------------------------------------
module acv_front
  import acv_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  item_t item,
  input  logic  hold,
  output logic  avail,
  output item_t head,
  input  logic  take
);
  item_t      slot [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_take;

  // no beats taken while the store is being cleared after reset
  assign full    = (count == 2'd2) || hold;
  assign avail   = (count != 2'd0);
  assign head    = slot[rd_ptr];
  assign do_push = push && !full;
  assign do_take = take && avail;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= item;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_take) rd_ptr <= !rd_ptr;
      count <= count + 2'(do_push) - 2'(do_take);
    end
  end
endmodule

// ===== rtl/core/acv_back.sv =====
// ----------------------------------------------------------------------------
// acv_back
// Executor: escape parser, cursor, cell writes, scroll and clear sweeps.
// ----------------------------------------------------------------------------
module acv_back
  import acv_pkg::*;
#(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    avail,
  input  item_t   head,
  output logic    take,
  output logic    init_busy,
  output logic    res_valid,
  output result_t res,
  input  logic    pop
);
  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS + TAB_WIDTH + 1);
  localparam int RW    = $clog2(ROWS + 1);
  localparam int PW    = $clog2(TAB_WIDTH);
  localparam int OW    = AW + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EMIT  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_SCRL  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_FILL  = 3'd5;

  logic [2:0]    state, state_next;
  logic [CW-1:0] col, col_next;
  logic [RW-1:0] row, row_next;
  logic [PW-1:0] phase, phase_next;
  logic [7:0]    text_attr, attr_next;
  logic [2:0]    esc_stage, stage_next;
  logic [7:0]    esc_digit, digit_next;
  logic [3:0]    pending_color, pend_next;
  logic [15:0]   data_reg;
  logic [AW-1:0] cnt;
  logic          pend_wr;
  logic [AW-1:0] pend_addr;
  logic          init_fill;
  logic          rd_ok;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata, rdata;
  logic          slot_free;

  // put decode
  logic          do_write, do_scroll, do_clear;
  logic [CW-1:0] wcol;
  logic [2:0]    stg;
  logic          consumed;
  logic [7:0]    c;

  acv_ram #(.WIDTH(16), .DEPTH(CELLS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign slot_free = !res_valid || pop;
  assign take      = (state == S_IDLE) && avail;
  assign init_busy = init_fill;
  assign c         = head.char_code;

  always_comb begin
    col_next   = col;
    row_next   = row;
    phase_next = phase;
    attr_next  = text_attr;
    stage_next = esc_stage;
    digit_next = esc_digit;
    pend_next  = pending_color;
    do_write   = 1'b0;
    do_scroll  = 1'b0;
    do_clear   = 1'b0;
    consumed   = 1'b0;
    wcol       = col;
    stg        = (esc_stage > ESC_COLOR) ? ESC_IDLE : esc_stage;
    case (stg)
      ESC_SEEN: begin
        if (c == CH_LBR) begin
          consumed = 1'b1; stage_next = ESC_CSI;
        end
      end
      ESC_CSI: begin
        if (c inside {CH_0, CH_1, CH_2, CH_3, CH_4, CH_7}) begin
          consumed = 1'b1; stage_next = ESC_DIGIT; digit_next = c;
        end
      end
      ESC_DIGIT: begin
        if (c inside {[CH_0:CH_7]}) begin
          if (esc_digit == CH_3 || esc_digit == CH_4) begin
            consumed   = 1'b1;
            pend_next  = colour_map(c[2:0]);
            stage_next = ESC_COLOR;
          end
        end else if (c == CH_J) begin
          if (esc_digit == CH_2) begin
            consumed = 1'b1; do_clear = 1'b1;
            col_next = '0; row_next = '0; phase_next = '0;
            stage_next = ESC_IDLE;
          end
        end else if (c == CH_M) begin
          if (esc_digit == CH_0) begin
            consumed = 1'b1; attr_next = ATTR_NORMAL; stage_next = ESC_IDLE;
          end else if (esc_digit == CH_1) begin
            consumed = 1'b1; attr_next = ATTR_BRIGHT; stage_next = ESC_IDLE;
          end else if (esc_digit == CH_2) begin
            consumed = 1'b1; attr_next = ATTR_REVERSE; stage_next = ESC_IDLE;
          end
        end
      end
      ESC_COLOR: begin
        if (c == CH_M && esc_digit == CH_3) begin
          consumed = 1'b1; attr_next = {text_attr[7:4], pending_color};
          stage_next = ESC_IDLE;
        end else if (c == CH_M && esc_digit == CH_4) begin
          consumed = 1'b1; attr_next = {pending_color, text_attr[3:0]};
          stage_next = ESC_IDLE;
        end
      end
      default: ;
    endcase
    if (!consumed) begin
      if (c == CH_ESC) begin
        stage_next = ESC_SEEN;
      end else begin
        stage_next = ESC_IDLE;
        if (c == CH_CR) begin
          col_next = '0; phase_next = '0;
        end else if (c == CH_LF) begin
          col_next = '0; phase_next = '0; row_next = row + 1'b1;
        end else if (c == CH_TAB) begin
          col_next   = col + CW'(TAB_WIDTH) - CW'(phase);
          phase_next = '0;
        end else if (c == CH_BS) begin
          // step back, write, step forward: net move only from column 0
          do_write = 1'b1;
          if (col != '0) begin
            wcol = col - 1'b1;
          end else begin
            wcol       = '0;
            col_next   = CW'(1);
            phase_next = PW'(1);
          end
        end else begin
          do_write   = 1'b1;
          col_next   = col + 1'b1;
          phase_next = (phase == PW'(TAB_WIDTH - 1)) ? '0 : phase + 1'b1;
        end
        if (col_next >= CW'(COLUMNS)) begin
          col_next = '0; phase_next = '0; row_next = row_next + 1'b1;
        end
        if (row_next >= RW'(ROWS)) begin
          do_scroll = 1'b1;
          row_next  = RW'(ROWS - 1);
        end
      end
    end
  end

  // RAM ports
  always_comb begin
    we    = 1'b0;
    waddr = cnt;
    wdata = {text_attr, CH_SPACE};
    raddr = cnt + AW'(COLUMNS);
    case (state)
      S_IDLE: begin
        raddr = AW'(head.cell_address);
        if (avail && head.cmd == CMD_PUT && do_write) begin
          we    = 1'b1;
          waddr = AW'(OW'(row) * OW'(COLUMNS) + OW'(wcol));
          wdata = {text_attr, c};
        end
      end
      S_SCRL: begin
        we = pend_wr; waddr = pend_addr; wdata = rdata;
      end
      S_DRAIN: begin
        we = 1'b1; waddr = pend_addr; wdata = rdata;
      end
      S_FILL: we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    pend_addr <= cnt;
    if (state == S_IDLE) begin
      data_reg <= '0;
      rd_ok    <= (32'(head.cell_address) < CELLS);
    end else if (state == S_READ) begin
      data_reg <= rd_ok ? rdata : '0;
    end
    if (state == S_EMIT && slot_free) begin
      res.cursor_col    <= 7'(col);
      res.cursor_row    <= 5'(row);
      res.cursor_offset <= 11'(OW'(row) * OW'(COLUMNS) + OW'(col));
      res.current_attr  <= text_attr;
      res.cell_data     <= data_reg;
      res.escape_stage  <= esc_stage;
    end
    if (rst) begin
      state         <= S_FILL;
      init_fill     <= 1'b1;
      cnt           <= '0;
      pend_wr       <= 1'b0;
      col           <= '0;
      row           <= '0;
      phase         <= '0;
      text_attr     <= ATTR_NORMAL;
      esc_stage     <= ESC_IDLE;
      esc_digit     <= '0;
      pending_color <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (state == S_EMIT && slot_free) begin
        res_valid <= 1'b1;
      end else if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (avail) begin
            case (head.cmd)
              CMD_PUT: begin
                col           <= col_next;
                row           <= row_next;
                phase         <= phase_next;
                text_attr     <= attr_next;
                esc_stage     <= stage_next;
                esc_digit     <= digit_next;
                pending_color <= pend_next;
                cnt           <= '0;
                pend_wr       <= 1'b0;
                if (do_clear) begin
                  state <= S_FILL;
                end else if (do_scroll) begin
                  state <= S_SCRL;
                end else begin
                  state <= S_EMIT;
                end
              end
              CMD_READ: state <= S_READ;
              CMD_ATTR: begin
                text_attr <= head.attr_value;
                state     <= S_EMIT;
              end
              default: state <= S_EMIT;
            endcase
          end
        end
        S_READ: state <= S_EMIT;
        S_SCRL: begin
          // read cell i+COLUMNS, write it to cell i in the next cycle
          pend_wr <= 1'b1;
          if (cnt == AW'(CELLS - COLUMNS - 1)) begin
            state <= S_DRAIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DRAIN: begin
          cnt   <= AW'(CELLS - COLUMNS);
          state <= S_FILL;
        end
        S_FILL: begin
          if (cnt == AW'(CELLS - 1)) begin
            init_fill <= 1'b0;
            state     <= init_fill ? S_IDLE : S_EMIT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
